// ===== rtl/button_debounce_press_classifier_assert.svh =====
// Assertion macros shared by the button debounce blocks.
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_ASSERT_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define BDPC_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A condition in one cycle that forces another in the next cycle.
`define BDPC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bdpc_pkg.sv =====
package bdpc_pkg;

    localparam int NUM_BUTTONS_DEF = 4;
    localparam int QUEUE_DEPTH_DEF = 5;
    localparam int MAX_BUTTONS     = 16;

    localparam int TICK_W     = 32;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int STORE_BTN_W = 4;
    localparam int RAW_W      = 4;
    localparam int QUERY_W    = 2;
    localparam int EV_BTN_W   = 2;
    localparam int COUNT_W    = 3;

    localparam int WORK_FIFO_DEPTH = 2;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd50;
    localparam logic [CFG_W-1:0] LONG_RESET     = 16'd500;
    localparam logic [CFG_W-1:0] SHORT_RESET    = 16'd50;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEBOUNCE = 2'd0,
        CFG_LONG     = 2'd1,
        CFG_SHORT    = 2'd2
    } t_cfg_idx;

    // Event kinds as stored in the queue.
    localparam logic KIND_SHORT = 1'b0;
    localparam logic KIND_LONG  = 1'b1;

    // Everything the back part needs from one classified tick.
    typedef struct packed {
        logic [MAX_BUTTONS-1:0] ev_mask;
        logic [MAX_BUTTONS-1:0] ev_kind;
        logic                   take;
        logic [RAW_W-1:0]       levels;
        logic                   qpressed;
    } t_work;

    typedef struct packed {
        logic [STORE_BTN_W-1:0] button;
        logic                   kind;
    } t_event;

endpackage

// ===== rtl/bdpc_front.sv =====
`include "button_debounce_press_classifier_assert.svh"

module bdpc_front #(
    parameter int NumButtons = bdpc_pkg::NUM_BUTTONS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [bdpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bdpc_pkg::CFG_W-1:0]    i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [bdpc_pkg::RAW_W-1:0]    i_raw_pressed,
    input  logic                          i_take_event,
    input  logic [bdpc_pkg::QUERY_W-1:0]  i_query_button,
    output logic                          o_work_valid,
    input  logic                          i_work_ready,
    output bdpc_pkg::t_work               o_work
);
    import bdpc_pkg::*;

    logic [CFG_W-1:0]  r_debounce;
    logic [CFG_W-1:0]  r_long;
    logic [CFG_W-1:0]  r_short;

    logic [TICK_W-1:0] r_tick;
    logic [NumButtons-1:0] r_stable, n_stable;
    logic [NumButtons-1:0] r_active, n_active;
    logic [TICK_W-1:0] r_cand [NumButtons];
    logic [TICK_W-1:0] n_cand [NumButtons];
    logic [TICK_W-1:0] r_last [NumButtons];
    logic [TICK_W-1:0] n_last [NumButtons];

    logic [TICK_W-1:0] cand_eff [NumButtons];
    logic [TICK_W-1:0] waited   [NumButtons];
    logic [TICK_W-1:0] held     [NumButtons];
    logic [NumButtons+RAW_W-1:0] raw_ext;
    logic              accept;
    t_work             work;

    assign accept       = i_in_valid && i_work_ready;
    assign o_in_ready   = i_work_ready;
    assign o_work_valid = i_in_valid;
    assign o_work       = work;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce <= DEBOUNCE_RESET;
            r_long     <= LONG_RESET;
            r_short    <= SHORT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_DEBOUNCE: r_debounce <= i_cfg_data;
                CFG_LONG:     r_long     <= i_cfg_data;
                CFG_SHORT:    r_short    <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // One lane per button; all lanes see the same tick stamp.
    always_comb begin
        raw_ext  = {{NumButtons{1'b0}}, i_raw_pressed};
        n_stable = r_stable;
        n_active = r_active;
        work     = '0;
        for (int i = 0; i < NumButtons; i++) begin
            n_cand[i]   = r_cand[i];
            n_last[i]   = r_last[i];
            cand_eff[i] = r_active[i] ? r_cand[i] : r_tick;
            waited[i]   = r_tick - cand_eff[i];
            held[i]     = cand_eff[i] - r_last[i];
            if (raw_ext[i] != r_stable[i]) begin
                if (waited[i] >= {{(TICK_W-CFG_W){1'b0}}, r_debounce}) begin
                    n_stable[i] = raw_ext[i];
                    if (!raw_ext[i]) begin
                        if (held[i] >= {{(TICK_W-CFG_W){1'b0}}, r_long}) begin
                            work.ev_mask[i] = 1'b1;
                            work.ev_kind[i] = KIND_LONG;
                        end else if (held[i] >= {{(TICK_W-CFG_W){1'b0}}, r_short}) begin
                            work.ev_mask[i] = 1'b1;
                            work.ev_kind[i] = KIND_SHORT;
                        end
                    end
                    n_last[i]   = cand_eff[i];
                    n_active[i] = 1'b0;
                    n_cand[i]   = '0;
                end else begin
                    n_active[i] = 1'b1;
                    n_cand[i]   = cand_eff[i];
                end
            end else begin
                n_active[i] = 1'b0;
                n_cand[i]   = '0;
            end
        end
        work.take = i_take_event;
        for (int i = 0; i < NumButtons; i++) begin
            if (i < RAW_W) begin
                work.levels[i] = n_stable[i];
            end
            if (i == int'(i_query_button)) begin
                work.qpressed = n_stable[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick   <= '0;
            r_stable <= '0;
            r_active <= '0;
            for (int i = 0; i < NumButtons; i++) begin
                r_cand[i] <= '0;
                r_last[i] <= '0;
            end
        end else if (accept) begin
            r_tick   <= r_tick + 1'b1;
            r_stable <= n_stable;
            r_active <= n_active;
            for (int i = 0; i < NumButtons; i++) begin
                r_cand[i] <= n_cand[i];
                r_last[i] <= n_last[i];
            end
        end
    end

    `BDPC_ASSERT_NEXT(a_levels_hold_when_idle, i_clk, i_rst_n, !accept,
        $stable(r_stable) && $stable(r_tick), "debounced levels moved without a transfer")

endmodule

// ===== rtl/bdpc_fifo.sv =====
`include "button_debounce_press_classifier_assert.svh"

module bdpc_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push_valid,
    output logic            o_push_ready,
    input  bdpc_pkg::t_work i_push_data,
    output logic            o_pop_valid,
    input  logic            i_pop_ready,
    output bdpc_pkg::t_work o_pop_data
);
    import bdpc_pkg::*;

    localparam int Depth = WORK_FIFO_DEPTH;
    localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW  = $clog2(Depth + 1);

    t_work            r_mem [Depth];
    logic [PtrW-1:0]  r_wr;
    logic [PtrW-1:0]  r_rd;
    logic [CntW-1:0]  r_count;
    logic             push;
    logic             pop;

    assign o_push_ready = (r_count != CntW'(Depth));
    assign o_pop_valid  = (r_count != '0);
    assign o_pop_data   = r_mem[r_rd];
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PtrW'(Depth - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= (r_rd == PtrW'(Depth - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `BDPC_ASSERT_ALWAYS(a_fifo_count_bound, i_clk, i_rst_n, r_count <= CntW'(Depth),
        "work queue count exceeds its depth")

endmodule

// ===== rtl/bdpc_back.sv =====
`include "button_debounce_press_classifier_assert.svh"

module bdpc_back #(
    parameter int NumButtons = bdpc_pkg::NUM_BUTTONS_DEF,
    parameter int QueueDepth = bdpc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_work_valid,
    output logic                          o_work_ready,
    input  bdpc_pkg::t_work               i_work,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_event_valid,
    output logic [bdpc_pkg::EV_BTN_W-1:0] o_event_button,
    output logic                          o_event_kind,
    output logic                          o_query_pressed,
    output logic [bdpc_pkg::RAW_W-1:0]    o_stable_levels,
    output logic [bdpc_pkg::COUNT_W-1:0]  o_queued_count
);
    import bdpc_pkg::*;

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);
    localparam int SumW = $clog2(QueueDepth + NumButtons + 1);

    t_event            r_store [QueueDepth];
    t_event            n_store [QueueDepth];
    logic [PtrW-1:0]   r_head, n_head;
    logic [CntW-1:0]   r_len, n_len;

    logic              r_out_valid;
    logic              r_ev_valid;
    logic [EV_BTN_W-1:0] r_ev_button;
    logic              r_ev_kind;
    logic              r_qpressed;
    logic [RAW_W-1:0]  r_levels;
    logic [COUNT_W-1:0] r_count;

    logic              take_work;
    logic [SumW-1:0]   rank;
    logic [SumW-1:0]   free;
    logic [SumW-1:0]   tail;
    logic [SumW-1:0]   slot;
    logic [CntW-1:0]   len_enq;
    logic              pop;
    t_event            head_entry;
    logic [CntW+COUNT_W-1:0] count_ext;

    assign o_work_ready = !r_out_valid || i_out_ready;
    assign take_work    = i_work_valid && o_work_ready;

    // Enqueue the tick's events in button order, dropping those that do not fit,
    // then pop after the enqueue so a fresh event can leave on the same tick.
    always_comb begin
        n_store = r_store;
        rank    = '0;
        slot    = '0;
        free    = SumW'(QueueDepth) - SumW'(r_len);
        tail    = SumW'(r_head) + SumW'(r_len);
        if (tail >= SumW'(QueueDepth)) begin
            tail = tail - SumW'(QueueDepth);
        end
        for (int i = 0; i < NumButtons; i++) begin
            if (i_work.ev_mask[i] && (rank < free)) begin
                slot = tail + rank;
                if (slot >= SumW'(QueueDepth)) begin
                    slot = slot - SumW'(QueueDepth);
                end
                n_store[slot[PtrW-1:0]] = '{button: STORE_BTN_W'(i), kind: i_work.ev_kind[i]};
                rank = rank + SumW'(1);
            end
        end
        len_enq    = r_len + rank[CntW-1:0];
        pop        = i_work.take && (len_enq != '0);
        head_entry = n_store[r_head];
        n_head     = r_head;
        n_len      = len_enq;
        if (pop) begin
            n_head = (r_head == PtrW'(QueueDepth - 1)) ? '0 : r_head + 1'b1;
            n_len  = len_enq - 1'b1;
        end
        count_ext = {{COUNT_W{1'b0}}, n_len};
    end

    always_ff @(posedge i_clk) begin
        if (take_work) begin
            r_store <= n_store;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_len       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (take_work) begin
                r_head      <= n_head;
                r_len       <= n_len;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_work) begin
            r_ev_valid  <= pop;
            r_ev_button <= pop ? head_entry.button[EV_BTN_W-1:0] : '0;
            r_ev_kind   <= pop ? head_entry.kind : 1'b0;
            r_qpressed  <= i_work.qpressed;
            r_levels    <= i_work.levels;
            r_count     <= count_ext[COUNT_W-1:0];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_event_valid   = r_ev_valid;
    assign o_event_button  = r_ev_button;
    assign o_event_kind    = r_ev_kind;
    assign o_query_pressed = r_qpressed;
    assign o_stable_levels = r_levels;
    assign o_queued_count  = r_count;

    `BDPC_ASSERT_ALWAYS(a_queue_len_bound, i_clk, i_rst_n, r_len <= CntW'(QueueDepth),
        "event queue length exceeds its depth")
    `BDPC_ASSERT_ALWAYS(a_queue_head_bound, i_clk, i_rst_n,
        {1'b0, r_head} < (PtrW + 1)'(QueueDepth), "event queue head out of range")
    `BDPC_ASSERT_ALWAYS(a_idle_event_zero, i_clk, i_rst_n,
        !r_out_valid || r_ev_valid || (r_ev_button == '0 && !r_ev_kind),
        "event fields not cleared on a result without a popped event")

endmodule

// ===== rtl/button_debounce_press_classifier.sv =====
// A tick's result passes through the work queue and then the back part's output registers.
// Throughput: one tick per cycle while the work queue has room; the per-button lanes and
// the event queue update are decoupled by a two-entry work queue.
// Reset (synchronous, active low) releases all buttons, zeroes the tick counter, empties
// both queues and restores the thresholds to 50, 500 and 50 ticks.
module button_debounce_press_classifier #(
    parameter int NumButtons = bdpc_pkg::NUM_BUTTONS_DEF,
    parameter int QueueDepth = bdpc_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bdpc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bdpc_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [bdpc_pkg::RAW_W-1:0]     i_raw_pressed,
    input  logic                           i_take_event,
    input  logic [bdpc_pkg::QUERY_W-1:0]   i_query_button,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic                           o_event_valid,
    output logic [bdpc_pkg::EV_BTN_W-1:0]  o_event_button,
    output logic                           o_event_kind,
    output logic                           o_query_pressed,
    output logic [bdpc_pkg::RAW_W-1:0]     o_stable_levels,
    output logic [bdpc_pkg::COUNT_W-1:0]   o_queued_count
);
    import bdpc_pkg::*;

    logic  front_valid;
    logic  front_ready;
    t_work front_work;
    logic  back_valid;
    logic  back_ready;
    t_work back_work;

    bdpc_front #(
        .NumButtons (NumButtons)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_raw_pressed  (i_raw_pressed),
        .i_take_event   (i_take_event),
        .i_query_button (i_query_button),
        .o_work_valid   (front_valid),
        .i_work_ready   (front_ready),
        .o_work         (front_work)
    );

    bdpc_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .o_push_ready (front_ready),
        .i_push_data  (front_work),
        .o_pop_valid  (back_valid),
        .i_pop_ready  (back_ready),
        .o_pop_data   (back_work)
    );

    bdpc_back #(
        .NumButtons (NumButtons),
        .QueueDepth (QueueDepth)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_work_valid    (back_valid),
        .o_work_ready    (back_ready),
        .i_work          (back_work),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_event_valid   (o_event_valid),
        .o_event_button  (o_event_button),
        .o_event_kind    (o_event_kind),
        .o_query_pressed (o_query_pressed),
        .o_stable_levels (o_stable_levels),
        .o_queued_count  (o_queued_count)
    );

endmodule
